// ----- rtl/lbachs_pkg.sv -----
// Package for the LBA to CHS converter: geometry defaults, register
// indexes and field widths shared by the RTL and the checker.
// No dependencies.
`default_nettype none

package lbachs_pkg;

   // field widths of the result transaction
   localparam int CYL_W    = 16;
   localparam int HEAD_W   = 8;
   localparam int SECTOR_W = 6;
   localparam int RSP_W    = 32;   // fields padded to whole bytes

   // divisor width of the shared divider (widest geometry register)
   localparam int DIVISOR_W = 8;

   // default linear address width
   localparam int LBA_WIDTH_DEFAULT = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_SECTORS_PER_TRACK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAD_COUNT        = 2'd1;

   // geometry after reset: 18 sectors, 2 heads
   localparam logic [SECTOR_W-1:0]  SPT_RESET = 6'd18;
   localparam logic [DIVISOR_W-1:0] HC_RESET  = 8'd2;

endpackage : lbachs_pkg

`default_nettype wire

// ----- rtl/lbachs_div.sv -----
// Shared restoring shift-and-subtract divider, one quotient bit a cycle.
// Depends on lbachs_pkg.
`default_nettype none

module lbachs_div
   import lbachs_pkg::*;
#(
   parameter int WIDTH = LBA_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WIDTH-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output logic                      done,
   output logic [WIDTH-1:0]          quotient,
   output logic [DIVISOR_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WIDTH-1:0]     quo_ff, quo_in;      // dividend bits out, quotient bits in
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;

   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule : lbachs_div

`default_nettype wire

// ----- rtl/lba_to_chs_converter.sv -----
// LBA to CHS converter. One request at a time: the single divider does two
// passes of LBA_WIDTH steps each (lba / spt, then track / hc), with a hand-over
// between them; the result is then loaded into the output register once that
// is free, and the sequencer returns to idle before taking the next request.
// Synchronous active-high reset returns the geometry to 18 sectors and
// 2 heads and empties the sequencer and output register.
// Depends on lbachs_pkg and lbachs_div.
`default_nettype none

module lba_to_chs_converter
   import lbachs_pkg::*;
#(
   parameter int LBA_WIDTH = LBA_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request: lba[LBA_WIDTH-1:0], zero padded to whole bytes
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [((LBA_WIDTH+7)/8)*8-1:0] req_tdata,
   // response: cylinder[15:0], head[23:16], sector[29:24], zero[31:30]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,
   // geometry register writes
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a request
   localparam logic [1:0] ST_TRACK = 2'd1;  // lba / sectors_per_track
   localparam logic [1:0] ST_CYL   = 2'd2;  // track / head_count
   localparam logic [1:0] ST_LOAD  = 2'd3;  // hand result to output register

   logic [1:0]           state_ff, state_in;
   logic [SECTOR_W-1:0]  spt_ff, spt_in;
   logic [DIVISOR_W-1:0] hc_ff, hc_in;
   logic [SECTOR_W-1:0]  sector_ff, sector_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 div_start;
   logic                 div_done;
   logic [LBA_WIDTH-1:0] div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [LBA_WIDTH-1:0] div_quotient;
   logic [DIVISOR_W-1:0] div_remainder;
   logic [SECTOR_W-1:0]  spt_eff;
   logic [DIVISOR_W-1:0] hc_eff;
   logic [LBA_WIDTH+CYL_W-1:0] cyl_ext;
   logic                 out_free;

   // a zero geometry register acts as one, so the divisor is never zero
   assign spt_eff = (spt_ff == '0) ? SECTOR_W'(1) : spt_ff;
   assign hc_eff  = (hc_ff == '0) ? DIVISOR_W'(1) : hc_ff;

   // configuration: always ready, unknown indexes dropped
   assign csr_ready = 1'b1;

   always_comb begin
      spt_in = spt_ff;
      hc_in  = hc_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SECTORS_PER_TRACK: spt_in = csr_wdata[SECTOR_W-1:0];
            REG_HEAD_COUNT:        hc_in  = csr_wdata[DIVISOR_W-1:0];
            default: ;
         endcase
      end
   end

   // --- sequencer around the shared divider ---
   // First pass: lba / spt gives the track index and (sector - 1).
   // Second pass: track / hc gives the cylinder and the head; this equals
   // lba / (spt * hc) without needing a multiplier.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign div_start    = req_accept || ((state_ff == ST_TRACK) && div_done);
   assign div_dividend = (state_ff == ST_IDLE) ? req_tdata[LBA_WIDTH-1:0] : div_quotient;
   assign div_divisor  = (state_ff == ST_IDLE) ? DIVISOR_W'(spt_eff) : hc_eff;

   // cylinder kept to 16 bits whatever the address width
   assign cyl_ext = {{CYL_W{1'b0}}, div_quotient};

   always_comb begin
      state_in     = state_ff;
      sector_in    = sector_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_TRACK;
            end
         end
         ST_TRACK: begin
            if (div_done) begin
               // remainder < spt <= 63, so +1 stays within six bits
               sector_in = div_remainder[SECTOR_W-1:0] + SECTOR_W'(1);
               state_in  = ST_CYL;
            end
         end
         ST_CYL: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // divider outputs hold until the next start
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, sector_ff, div_remainder, cyl_ext[CYL_W-1:0]};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spt_ff       <= SPT_RESET;
         hc_ff        <= HC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spt_ff       <= spt_in;
         hc_ff        <= hc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sector_ff   <= sector_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   lbachs_div #(
      .WIDTH (LBA_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

endmodule : lba_to_chs_converter

`default_nettype wire

// ----- rtl/lbachs_checker.sv -----
// Port-level checker for the LBA to CHS converter, bound to the top level.
// Depends on lbachs_pkg.
`default_nettype none

module lbachs_checker
   import lbachs_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // one request in flight: busy right after a request transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a conversion is running");

   // sector counts from one
   a_sector_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:24] != 6'd0)
      else $error("sector zero on response");

   // padding bits stay clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:30] == 2'b00)
      else $error("response padding not zero");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

endmodule : lbachs_checker

bind lba_to_chs_converter lbachs_checker u_lbachs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- sim/lba_to_chs_converter_tb.sv -----
// Self-checking testbench for lba_to_chs_converter: directed geometry corners, then
// random traffic under sender gaps and receiver stalls, checked by a local predictor.
// Depends on lbachs_pkg and the converter RTL only.
`timescale 1ns / 1ps

module lba_to_chs_converter_tb;
   import lbachs_pkg::*;

   localparam int LBA_W       = LBA_WIDTH_DEFAULT;
   localparam int LATENCY     = 2*LBA_W + 3;       // req transaction to rsp_tvalid
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PRINT_LIMIT = 100;

   // indexes with no register behind them; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {RX_READY, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_type;

   // one predicted response, with the address that caused it for messages
   typedef struct {
      logic [LBA_W-1:0]    lba;
      logic [CYL_W-1:0]    cylinder;
      logic [HEAD_W-1:0]   head;
      logic [SECTOR_W-1:0] sector;
   } chs_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [LBA_W-1:0]       req_tdata = '0;     // lba
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;          // cylinder, head, sector, zero pad
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // local copy of the geometry registers, updated on each accepted write
   logic [SECTOR_W-1:0]    geo_spt = SPT_RESET;
   logic [DIVISOR_W-1:0]   geo_hc  = HC_RESET;

   chs_type                chs_due[$];         // responses still owed by the block
   chs_type                want;
   int                     err_count = 0;
   int                     cycles = 0;

   // receiver stall state
   bit                     rx_free = 1'b0;
   rx_mode_type            rx_mode = RX_READY;
   int                     rx_stretch = 0;
   int                     rx_hold = 0;

   lba_to_chs_converter #(
      .LBA_WIDTH(LBA_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("lba_to_chs_converter regression: fail");
         $finish;
      end
   end

   // Predictor. A zero geometry register counts as one, so the divisors are
   // never zero; quotients are cut back to the field widths.
   function automatic chs_type convert_lba(input logic [LBA_W-1:0] lba);
      int unsigned spt;
      int unsigned hc;
      chs_type     r;
      spt = (geo_spt == '0) ? 1 : geo_spt;
      hc  = (geo_hc == '0) ? 1 : geo_hc;
      r.lba      = lba;
      r.cylinder = CYL_W'(lba / (spt * hc));
      r.head     = HEAD_W'((lba / spt) % hc);
      r.sector   = SECTOR_W'((lba % spt) + 1);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Sends one lba. With hold set, tvalid stays high for the next transaction
   // so a burst goes out without bubbles.
   task automatic send_lba(input logic [LBA_W-1:0] lba, input bit hold);
      req_tdata  = lba;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chs_due.push_back(convert_lba(lba));
      @(negedge clock);
      if (!hold)
         req_tvalid = 1'b0;
   endtask

   // Geometry write; sectors per track keeps only the low six bits, and spare
   // indexes leave the geometry alone.
   task automatic write_geometry(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SECTORS_PER_TRACK: geo_spt = val[SECTOR_W-1:0];
         REG_HEAD_COUNT:        geo_hc  = val[DIVISOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Every accepted lba yields exactly one response, so an empty queue means
   // the block is idle.
   task automatic drain_results();
      while (chs_due.size() != 0) @(negedge clock);
   endtask

   // Random traffic under the current geometry. Quiet mode: one unbroken
   // burst and a receiver that never stalls.
   task automatic run_traffic(input int n_items, input bit quiet);
      int unsigned spt;
      int unsigned per_cyl;
      int          burst_left;
      int          v;
      burst_left = 0;
      rx_free    = quiet;
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_left = quiet ? n_items : $urandom_range(1, 8);
            // now and then hold off until the block has emptied completely
            if (!quiet && $urandom_range(0, 39) == 0)
               drain_results();
            if (!quiet)
               repeat ($urandom_range(1, 40)) @(negedge clock);
         end
         burst_left--;
         spt     = (geo_spt == '0) ? 1 : geo_spt;
         per_cyl = spt * ((geo_hc == '0) ? 1 : geo_hc);
         case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 63);
            1: v = $urandom_range(65535 - 63, 65535);
            // straddle a cylinder boundary
            2: v = $urandom_range(0, 65535 / per_cyl) * per_cyl + $urandom_range(0, 2) - 1;
            // straddle a track boundary
            3: v = $urandom_range(0, 65535 / spt) * spt + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(0, 65535);
         endcase
         if (v < 0)
            v = 0;
         else if (v > 65535)
            v = 65535;
         send_lba(LBA_W'(v), burst_left != 0 && i != n_items - 1);
      end
      rx_free = 1'b0;
   endtask

   // Receiver: back-pressure changes character every stretch of cycles;
   // the blocks pattern alternates runs of ready and runs of stall.
   always @(negedge clock) begin
      if (rx_stretch == 0) begin
         rx_mode    = rx_free ? RX_READY : rx_mode_type'($urandom_range(0, 3));
         rx_stretch = $urandom_range(20, 200);
      end else begin
         rx_stretch--;
      end
      if (rx_free)
         rx_mode = RX_READY;
      case (rx_mode)
         RX_READY:  rsp_tready = 1'b1;
         RX_COIN:   rsp_tready = $urandom_range(0, 1);
         RX_SPARSE: rsp_tready = ($urandom_range(0, 3) == 0);
         RX_BLOCKS: begin
            if (rx_hold == 0) begin
               rsp_tready = ~rsp_tready;
               rx_hold    = $urandom_range(1, 40);
            end else begin
               rx_hold--;
            end
         end
      endcase
   end

   // Response checker: each transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chs_due.size() == 0) begin
            report_mismatch($sformatf("response with none pending, tdata %h", rsp_tdata));
         end else begin
            want = chs_due.pop_front();
            if (rsp_tdata[CYL_W-1:0] !== want.cylinder)
               report_mismatch($sformatf("lba %0d spt %0d hc %0d: cylinder %0d, want %0d",
                  want.lba, geo_spt, geo_hc, rsp_tdata[CYL_W-1:0], want.cylinder));
            if (rsp_tdata[CYL_W +: HEAD_W] !== want.head)
               report_mismatch($sformatf("lba %0d spt %0d hc %0d: head %0d, want %0d",
                  want.lba, geo_spt, geo_hc, rsp_tdata[CYL_W +: HEAD_W], want.head));
            if (rsp_tdata[CYL_W+HEAD_W +: SECTOR_W] !== want.sector)
               report_mismatch($sformatf("lba %0d spt %0d hc %0d: sector %0d, want %0d",
                  want.lba, geo_spt, geo_hc, rsp_tdata[CYL_W+HEAD_W +: SECTOR_W],
                  want.sector));
            if (rsp_tdata[RSP_W-1:CYL_W+HEAD_W+SECTOR_W] !== '0)
               report_mismatch($sformatf("lba %0d: pad bits not zero, tdata %h",
                  want.lba, rsp_tdata));
         end
      end
   end

   // Reset geometry of 18 sectors and 2 heads: track and cylinder edges and
   // the extremes of lba, sent back to back.
   task automatic test_reset_geometry();
      logic [LBA_W-1:0] lbas[8];
      lbas = '{16'd0, 16'd17, 16'd18, 16'd35, 16'd36, 16'h5555, 16'hAAAA, 16'hFFFF};
      foreach (lbas[i])
         send_lba(lbas[i], i != 7);
   endtask

   // Geometry corners: largest and smallest, zero registers (read as one),
   // over-wide write data and writes to the spare indexes.
   task automatic test_geometry_extremes();
      drain_results();
      write_geometry(REG_SECTORS_PER_TRACK, 8'd63);
      write_geometry(REG_HEAD_COUNT, 8'd255);
      send_lba(16'd16064, 1'b1);                   // last sector of cylinder 0
      send_lba(16'd16065, 1'b1);
      send_lba(16'hFFFF, 1'b0);

      drain_results();
      write_geometry(REG_SECTORS_PER_TRACK, 8'd1);
      write_geometry(REG_HEAD_COUNT, 8'd1);
      send_lba(16'hFFFF, 1'b1);                    // widest cylinder
      send_lba(16'd0, 1'b0);

      drain_results();
      write_geometry(REG_SECTORS_PER_TRACK, 8'd0);
      write_geometry(REG_HEAD_COUNT, 8'd0);
      send_lba(16'hFFFF, 1'b1);
      send_lba(16'd12345, 1'b0);

      drain_results();
      write_geometry(REG_SECTORS_PER_TRACK, 8'hFF);  // keeps 63
      write_geometry(REG_HEAD_COUNT, 8'h80);
      write_geometry(REG_SPARE_2, 8'h00);
      write_geometry(REG_SPARE_3, 8'h00);
      send_lba(16'hFFFF, 1'b1);
      send_lba(16'd4000, 1'b0);

      drain_results();
      write_geometry(REG_SECTORS_PER_TRACK, 8'hC1);  // keeps 1
      write_geometry(REG_HEAD_COUNT, 8'h7F);
      send_lba(16'hFFFF, 1'b0);
   endtask

   // Full rate with no stalls on either side, with one pause mid-way until
   // every outstanding response is back.
   task automatic test_back_to_back();
      drain_results();
      write_geometry(REG_SECTORS_PER_TRACK, 8'd18);
      write_geometry(REG_HEAD_COUNT, 8'd2);
      run_traffic(30, 1'b1);
      drain_results();
      run_traffic(10, 1'b1);
   endtask

   // Random geometries, extremes included, each followed by a phase of
   // random traffic with gaps and stalls.
   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] spt_val;
      logic [CSR_DATA_W-1:0] hc_val;
      for (int phase = 0; phase < 10; phase++) begin
         drain_results();
         case ($urandom_range(0, 5))
            0: spt_val = 8'd0;
            1: spt_val = 8'd1;
            2: spt_val = 8'd63;
            3: spt_val = $urandom_range(64, 255);
            default: spt_val = $urandom_range(1, 63);
         endcase
         case ($urandom_range(0, 4))
            0: hc_val = 8'd0;
            1: hc_val = 8'd1;
            2: hc_val = 8'd255;
            default: hc_val = $urandom_range(1, 255);
         endcase
         if ($urandom_range(0, 1)) begin
            write_geometry(REG_SECTORS_PER_TRACK, spt_val);
            write_geometry(REG_HEAD_COUNT, hc_val);
         end else begin
            write_geometry(REG_HEAD_COUNT, hc_val);
            write_geometry(REG_SECTORS_PER_TRACK, spt_val);
         end
         if ($urandom_range(0, 2) == 0)
            write_geometry($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                           $urandom_range(0, 255));
         run_traffic(121, 1'b0);
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_reset_geometry();
      test_geometry_extremes();
      test_back_to_back();
      test_random_traffic();

      // all responses in, then watch a while for strays
      drain_results();
      repeat (2*LATENCY) @(negedge clock);
      if (err_count == 0)
         $display("lba_to_chs_converter regression: pass");
      else
         $display("lba_to_chs_converter regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lbachs_pkg.sv
rtl/lbachs_div.sv
rtl/lba_to_chs_converter.sv
rtl/lbachs_checker.sv
sim/lba_to_chs_converter_tb.sv
